>>> design/rast_pkg.sv
// Shared constants, register indexes and beat types for the ray/box slab test.
package rast_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int DIV_STEPS = WORD_W;
    localparam int N_AXES    = 3;
    localparam int N_LANES   = 2 * N_AXES;
    // entry stages + divider cells + interval stages
    localparam int LATENCY   = 3 + DIV_STEPS + 6;

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_T_LIMIT  = 3'd6;

    // one division in flight: partial remainder, numerator bits still to
    // shift in (quotient bits fill in from the bottom), sign, overflow
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] bits;
        logic              neg;
        logic              ovf;
    } div_lane_t;

    typedef struct packed {
        logic [WORD_W-1:0] mag;
        logic              neg;
        logic              ovf;
    } quo_t;

    typedef struct packed {
        logic valid;
        logic zmiss;
    } beat_ctl_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [WORD_W-2:0] t_enter;
        logic [WORD_W-2:0] t_exit;
    } res_t;

endpackage

>>> design/rast_div_cell.sv
// One restoring-division step: produce one quotient bit and pass the lane on.
module rast_div_cell
    import rast_pkg::*;
(
    input  logic              clk,
    input  div_lane_t         lane_in,
    input  logic [WORD_W-1:0] divisor,
    output div_lane_t         lane_out
);

    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   diff;
    logic              ge;
    div_lane_t         lane_next;
    div_lane_t         lane_reg;

    always_comb
    begin
        shifted        = {lane_in.rem[WORD_W-2:0], lane_in.bits[WORD_W-1]};
        diff           = {1'b0, shifted} - {1'b0, divisor};
        ge             = ~diff[WORD_W];
        lane_next.rem  = ge ? diff[WORD_W-1:0] : shifted;
        lane_next.bits = {lane_in.bits[WORD_W-2:0], ge};
        lane_next.neg  = lane_in.neg;
        lane_next.ovf  = lane_in.ovf;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

>>> design/rast_div_chain.sv
// Row of registered division cells: one quotient bit per cell.
module rast_div_chain
    import rast_pkg::*;
(
    input  logic              clk,
    input  div_lane_t         lane_in,
    input  logic [WORD_W-1:0] divisor,
    output quo_t              quo_out
);

    div_lane_t link [DIV_STEPS+1];

    assign link[0] = lane_in;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : gen_cell
        rast_div_cell u_cell (
            .clk      (clk),
            .lane_in  (link[g]),
            .divisor  (divisor),
            .lane_out (link[g+1])
        );
    end

    // after the last step the shift register holds the quotient magnitude
    assign quo_out.mag = link[DIV_STEPS].bits;
    assign quo_out.neg = link[DIV_STEPS].neg;
    assign quo_out.ovf = link[DIV_STEPS].ovf;

endmodule

>>> design/rast_interval.sv
// Saturate, order, widen and clip the six slab distances into the hit interval.
module rast_interval
    import rast_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  beat_ctl_t         ctl_in,
    input  quo_t              quo_in [N_LANES],
    input  logic [N_AXES-1:0] dir_zero,
    input  logic [WORD_W-2:0] t_limit,
    output res_t              res
);

    beat_ctl_t ctl_reg [5];

    logic signed [WORD_W-1:0] sat_next [N_LANES];
    logic signed [WORD_W-1:0] sat_reg  [N_LANES];
    logic signed [WORD_W-1:0] tn_next  [N_AXES];
    logic signed [WORD_W-1:0] tf_next  [N_AXES];
    logic signed [WORD_W-1:0] tn_reg   [N_AXES];
    logic signed [WORD_W-1:0] tf_reg   [N_AXES];
    logic signed [WORD_W-1:0] tnm_next [N_AXES];
    logic signed [WORD_W-1:0] tfm_next [N_AXES];
    logic signed [WORD_W-1:0] tnm_reg  [N_AXES];
    logic signed [WORD_W-1:0] tfm_reg  [N_AXES];
    logic signed [WORD_W-1:0] lim_s;
    logic signed [WORD_W-1:0] e01_next, e12_next, l01_next, l12_next;
    logic signed [WORD_W-1:0] e01_reg, e12_reg, l01_reg, l12_reg;
    logic signed [WORD_W-1:0] enter_next, leave_next;
    logic signed [WORD_W-1:0] enter_reg, leave_reg;
    logic                     hit_next;
    res_t                     res_next;
    res_t                     res_reg;

    // saturate the truncated quotient to the signed word
    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            if (quo_in[i].neg)
            begin
                if (quo_in[i].ovf || (quo_in[i].mag > 32'h8000_0000))
                    sat_next[i] = S32_MIN;
                else
                    sat_next[i] = -$signed(quo_in[i].mag);
            end
            else
            begin
                if (quo_in[i].ovf || quo_in[i].mag[WORD_W-1])
                    sat_next[i] = S32_MAX;
                else
                    sat_next[i] = $signed(quo_in[i].mag);
            end
        end
    end

    // order near and far per axis
    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            if (sat_reg[a] > sat_reg[a+N_AXES])
            begin
                tn_next[a] = sat_reg[a+N_AXES];
                tf_next[a] = sat_reg[a];
            end
            else
            begin
                tn_next[a] = sat_reg[a];
                tf_next[a] = sat_reg[a+N_AXES];
            end
        end
    end

    // widen far by one LSB unless saturated; a zero-direction axis sets no bound
    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            if (dir_zero[a])
            begin
                tnm_next[a] = '0;
                tfm_next[a] = S32_MAX;
            end
            else
            begin
                tnm_next[a] = tn_reg[a];
                tfm_next[a] = (tf_reg[a] == S32_MAX) ? tf_reg[a] : tf_reg[a] + 32'sd1;
            end
        end
    end

    always_comb
    begin
        lim_s    = $signed({1'b0, t_limit});
        e01_next = (tnm_reg[0] > 32'sd0) ? tnm_reg[0] : 32'sd0;
        e12_next = (tnm_reg[1] > tnm_reg[2]) ? tnm_reg[1] : tnm_reg[2];
        l01_next = (tfm_reg[0] < lim_s) ? tfm_reg[0] : lim_s;
        l12_next = (tfm_reg[1] < tfm_reg[2]) ? tfm_reg[1] : tfm_reg[2];
    end

    always_comb
    begin
        enter_next = (e01_reg > e12_reg) ? e01_reg : e12_reg;
        leave_next = (l01_reg < l12_reg) ? l01_reg : l12_reg;
    end

    always_comb
    begin
        hit_next         = ~ctl_reg[4].zmiss && (enter_reg <= leave_reg);
        res_next.done    = ctl_reg[4].valid;
        res_next.hit     = hit_next;
        res_next.t_enter = hit_next ? enter_reg[WORD_W-2:0] : '0;
        res_next.t_exit  = hit_next ? leave_reg[WORD_W-2:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
                ctl_reg[s] <= '0;
            res_reg <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s < 5; s++)
                ctl_reg[s] <= ctl_reg[s-1];
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg             <= sat_next;
        tn_reg              <= tn_next;
        tf_reg              <= tf_next;
        tnm_reg             <= tnm_next;
        tfm_reg             <= tfm_next;
        e01_reg             <= e01_next;
        e12_reg             <= e12_next;
        l01_reg             <= l01_next;
        l12_reg             <= l12_next;
        enter_reg           <= enter_next;
        leave_reg           <= leave_next;
    end

    assign res = res_reg;

endmodule

>>> design/ray_aabb_slab_test.sv
// Top level of the ray versus axis-aligned box slab test pipeline.
//
//  channel   | signals                                   | beat taken when
//  ----------+-------------------------------------------+-------------------------
//  config    | wr_en, wr_idx, wr_data                    | rising edge, wr_en high
//  box in    | start, busy, box_lo_{x,y,z}, box_hi_{x,y,z}| rising edge, start & !busy
//  result    | done, hit, t_enter, t_exit                | rising edge ending done
//
// One box is taken every cycle; busy is never raised. Each result follows
// its box through three entry stages (corner minus origin, magnitude and
// sign, overflow check), a row of 32 division cells that form one quotient
// bit each, and six stages of saturation and interval clipping. The
// division row sets the latency.
// Reset clears the ray registers to zero and empties the pipeline.
// The receiver cannot stall: each result is shown for one cycle only.
// Write the ray registers only while no box is in flight.
module ray_aabb_slab_test
    import rast_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // ray configuration
    input  logic                     wr_en,
    input  logic [2:0]               wr_idx,
    input  logic [WORD_W-1:0]        wr_data,
    // box beat
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] box_lo_x,
    input  logic signed [WORD_W-1:0] box_lo_y,
    input  logic signed [WORD_W-1:0] box_lo_z,
    input  logic signed [WORD_W-1:0] box_hi_x,
    input  logic signed [WORD_W-1:0] box_hi_y,
    input  logic signed [WORD_W-1:0] box_hi_z,
    // result beat
    output logic                     done,
    output logic                     hit,
    output logic [WORD_W-2:0]        t_enter,
    output logic [WORD_W-2:0]        t_exit
);

    // ray registers; the direction magnitude is formed once at write time
    logic signed [WORD_W-1:0] origin_reg   [N_AXES];
    logic signed [WORD_W-1:0] dir_reg      [N_AXES];
    logic        [WORD_W-1:0] dir_mag_reg  [N_AXES];
    logic        [WORD_W-1:0] dir_mag_next;
    logic        [WORD_W-2:0] limit_reg;
    logic        [N_AXES-1:0] dir_zero;

    // lanes 0..2 are the low corners of x, y, z; lanes 3..5 the high corners
    logic signed [WORD_W-1:0] corner      [N_LANES];
    logic signed [WORD_W:0]   d_next      [N_LANES];
    logic signed [WORD_W:0]   d_reg       [N_LANES];
    logic        [WORD_W:0]   d_neg       [N_LANES];
    logic        [WORD_W-1:0] dmag_next   [N_LANES];
    logic        [WORD_W-1:0] dmag_reg    [N_LANES];
    logic                     sneg_next   [N_LANES];
    logic                     sneg_reg    [N_LANES];
    logic        [NUM_W-1:0]  num_mag     [N_LANES];
    div_lane_t                lane_next   [N_LANES];
    div_lane_t                lane_reg    [N_LANES];
    quo_t                     quo         [N_LANES];

    logic                     p0_valid_reg;
    logic                     zmiss_next;
    beat_ctl_t                ctl_p1_reg;
    beat_ctl_t                ctl_p2_reg;
    beat_ctl_t                ctl_dly_reg [DIV_STEPS];
    res_t                     res;

    // the pipeline takes a box every cycle
    assign busy = 1'b0;

    assign corner[0] = box_lo_x;
    assign corner[1] = box_lo_y;
    assign corner[2] = box_lo_z;
    assign corner[3] = box_hi_x;
    assign corner[4] = box_hi_y;
    assign corner[5] = box_hi_z;

    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
            dir_zero[a] = (dir_reg[a] == '0);
        dir_mag_next = wr_data[WORD_W-1] ? (~wr_data + 32'd1) : wr_data;
    end

    // --------------------------------------------------------------------
    // Configuration writes
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                origin_reg[a]  <= '0;
                dir_reg[a]     <= '0;
                dir_mag_reg[a] <= '0;
            end
            limit_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_ORIGIN_X: origin_reg[0] <= $signed(wr_data);
                REG_ORIGIN_Y: origin_reg[1] <= $signed(wr_data);
                REG_ORIGIN_Z: origin_reg[2] <= $signed(wr_data);
                REG_DIR_X:
                begin
                    dir_reg[0]     <= $signed(wr_data);
                    dir_mag_reg[0] <= dir_mag_next;
                end
                REG_DIR_Y:
                begin
                    dir_reg[1]     <= $signed(wr_data);
                    dir_mag_reg[1] <= dir_mag_next;
                end
                REG_DIR_Z:
                begin
                    dir_reg[2]     <= $signed(wr_data);
                    dir_mag_reg[2] <= dir_mag_next;
                end
                REG_T_LIMIT:  limit_reg <= wr_data[WORD_W-2:0];
                default:      ; // drop writes beyond the register list
            endcase
        end
    end

    // --------------------------------------------------------------------
    // Entry stages
    // --------------------------------------------------------------------
    // stage 0: corner minus origin, exact in 33 bits
    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            d_next[a]        = $signed({corner[a][WORD_W-1], corner[a]})
                             - $signed({origin_reg[a][WORD_W-1], origin_reg[a]});
            d_next[a+N_AXES] = $signed({corner[a+N_AXES][WORD_W-1], corner[a+N_AXES]})
                             - $signed({origin_reg[a][WORD_W-1], origin_reg[a]});
        end
    end

    // stage 1: magnitude, quotient sign, containment check on flat axes
    always_comb
    begin
        zmiss_next = 1'b0;
        for (int i = 0; i < N_LANES; i++)
        begin
            d_neg[i]     = ~d_reg[i] + 33'd1;
            dmag_next[i] = d_reg[i][WORD_W] ? d_neg[i][WORD_W-1:0] : d_reg[i][WORD_W-1:0];
        end
        for (int a = 0; a < N_AXES; a++)
        begin
            sneg_next[a]        = d_reg[a][WORD_W] ^ dir_reg[a][WORD_W-1];
            sneg_next[a+N_AXES] = d_reg[a+N_AXES][WORD_W] ^ dir_reg[a][WORD_W-1];
            // origin below lo: lo - origin > 0; origin above hi: hi - origin < 0
            if (dir_zero[a] && ((d_reg[a] > 33'sd0) || d_reg[a+N_AXES][WORD_W]))
                zmiss_next = 1'b1;
        end
    end

    // stage 2: scale by the fraction bits, split for the division row and
    // flag quotients that cannot fit in 32 bits
    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                num_mag[a+s*N_AXES]        = {dmag_reg[a+s*N_AXES], {FRAC_BITS{1'b0}}};
                lane_next[a+s*N_AXES].rem  = {{(WORD_W-FRAC_BITS){1'b0}},
                                              num_mag[a+s*N_AXES][NUM_W-1:WORD_W]};
                lane_next[a+s*N_AXES].bits = num_mag[a+s*N_AXES][WORD_W-1:0];
                lane_next[a+s*N_AXES].neg  = sneg_reg[a+s*N_AXES];
                lane_next[a+s*N_AXES].ovf  = (lane_next[a+s*N_AXES].rem >= dir_mag_reg[a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        dmag_reg <= dmag_next;
        sneg_reg <= sneg_next;
        lane_reg <= lane_next;
    end

    // control travels beside the payload; a beat whose valid is low is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            ctl_p1_reg   <= '0;
            ctl_p2_reg   <= '0;
            for (int k = 0; k < DIV_STEPS; k++)
                ctl_dly_reg[k] <= '0;
        end
        else
        begin
            p0_valid_reg     <= start && !busy;
            ctl_p1_reg.valid <= p0_valid_reg;
            ctl_p1_reg.zmiss <= zmiss_next;
            ctl_p2_reg       <= ctl_p1_reg;
            ctl_dly_reg[0]   <= ctl_p2_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                ctl_dly_reg[k] <= ctl_dly_reg[k-1];
        end
    end

    // --------------------------------------------------------------------
    // Division rows: six slab distances, one per corner and axis
    // --------------------------------------------------------------------
    for (genvar a = 0; a < N_AXES; a++)
    begin : gen_axis
        rast_div_chain u_chain_lo (
            .clk     (clk),
            .lane_in (lane_reg[a]),
            .divisor (dir_mag_reg[a]),
            .quo_out (quo[a])
        );

        rast_div_chain u_chain_hi (
            .clk     (clk),
            .lane_in (lane_reg[a+N_AXES]),
            .divisor (dir_mag_reg[a]),
            .quo_out (quo[a+N_AXES])
        );
    end

    // --------------------------------------------------------------------
    // Interval clipping and result register
    // --------------------------------------------------------------------
    rast_interval u_interval (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_dly_reg[DIV_STEPS-1]),
        .quo_in   (quo),
        .dir_zero (dir_zero),
        .t_limit  (limit_reg),
        .res      (res)
    );

    assign done    = res.done;
    assign hit     = res.hit;
    assign t_enter = res.t_enter;
    assign t_exit  = res.t_exit;

    // --------------------------------------------------------------------
    // Assertions
    // --------------------------------------------------------------------
    a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (t_enter <= t_exit))
        else $error("hit with entry beyond exit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> ((t_enter == '0) && (t_exit == '0)))
        else $error("miss with nonzero distances");

    a_exit_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (t_exit <= limit_reg))
        else $error("exit distance beyond ray limit");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a box taken LATENCY cycles before");

endmodule

>>> tb/tb_ray_aabb_slab_test.sv
// Self-checking bench for the ray versus axis-aligned box slab test pipeline.
`timescale 1ns / 1ps

module tb_ray_aabb_slab_test;
    import rast_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    // The longest honest quiet stretch is a long sender gap plus the
    // pipeline latency plus the settle time before a register write.
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 10;
    localparam int BOXES_PER_PHASE = 113;
    localparam int SHOWN_ERRORS    = 10;

    typedef enum int {RAY_NEAR, RAY_WILD, RAY_EXTREME} ray_kind_t;

    // index 0 is the x axis, 1 is y, 2 is z
    typedef struct packed {
        logic [N_AXES-1:0][WORD_W-1:0] lo;
        logic [N_AXES-1:0][WORD_W-1:0] hi;
    } box_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-2:0] t_enter;
        logic [WORD_W-2:0] t_exit;
    } slab_res_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     wr_en = 1'b0;
    logic [2:0]               wr_idx = REG_ORIGIN_X;
    logic [WORD_W-1:0]        wr_data = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [WORD_W-1:0] box_lo_x = '0;
    logic signed [WORD_W-1:0] box_lo_y = '0;
    logic signed [WORD_W-1:0] box_lo_z = '0;
    logic signed [WORD_W-1:0] box_hi_x = '0;
    logic signed [WORD_W-1:0] box_hi_y = '0;
    logic signed [WORD_W-1:0] box_hi_z = '0;
    logic                     done;
    logic                     hit;
    logic [WORD_W-2:0]        t_enter;
    logic [WORD_W-2:0]        t_exit;

    // Our copy of the ray registers, at their reset values.
    logic [N_AXES-1:0][WORD_W-1:0] ray_org = '0;
    logic [N_AXES-1:0][WORD_W-1:0] ray_dir = '0;
    logic [WORD_W-2:0]             ray_limit = '0;

    box_t      box_backlog[$];     // boxes waiting for the driver
    slab_res_t owed_results[$];    // predictions for boxes already taken
    box_t      cur_box;

    int gap_left       = 0;
    int calm_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int boxes_sent     = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int ray_settings   = 0;

    ray_aabb_slab_test u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .start    (start),
        .busy     (busy),
        .box_lo_x (box_lo_x),
        .box_lo_y (box_lo_y),
        .box_lo_z (box_lo_z),
        .box_hi_x (box_hi_x),
        .box_hi_y (box_hi_y),
        .box_hi_z (box_hi_z),
        .done     (done),
        .hit      (hit),
        .t_enter  (t_enter),
        .t_exit   (t_exit)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Slab arithmetic, done in 64 bits so nothing wraps on the way
    // ------------------------------------------------------------------

    function automatic longint clamp_word(longint v);
        if (v > longint'(S32_MAX))
            return longint'(S32_MAX);
        if (v < longint'(S32_MIN))
            return longint'(S32_MIN);
        return v;
    endfunction

    function automatic longint fx(int n);
        return longint'(n) <<< FRAC_BITS;
    endfunction

    // Distance along the ray to one slab plane; dir must be nonzero.
    // SystemVerilog division truncates toward zero, as the block does.
    function automatic longint plane_dist(longint corner, longint org, longint dir);
        longint num;
        num = (corner - org) * (longint'(1) <<< FRAC_BITS);
        return clamp_word(num / dir);
    endfunction

    // Clip [0, limit] against the three slabs of one box.
    function automatic slab_res_t predict_slab(box_t b);
        longint    enter;
        longint    leave;
        longint    org;
        longint    dir;
        longint    lo;
        longint    hi;
        longint    near_t;
        longint    far_t;
        longint    swap_t;
        logic      alive;
        slab_res_t r;
        enter = 0;
        leave = longint'(ray_limit);
        alive = 1'b1;
        for (int a = 0; a < N_AXES && alive; a++)
        begin
            org = longint'($signed(ray_org[a]));
            dir = longint'($signed(ray_dir[a]));
            lo  = longint'($signed(b.lo[a]));
            hi  = longint'($signed(b.hi[a]));
            if (dir == 0)
            begin
                // parallel to the slab: the origin must sit between the planes
                if (org < lo || org > hi)
                    alive = 1'b0;
            end
            else
            begin
                near_t = plane_dist(lo, org, dir);
                far_t  = plane_dist(hi, org, dir);
                if (near_t > far_t)
                begin
                    swap_t = near_t;
                    near_t = far_t;
                    far_t  = swap_t;
                end
                // widen the exit by one LSB, short of the top of the range
                if (far_t < longint'(S32_MAX))
                    far_t = far_t + 1;
                if (near_t > enter)
                    enter = near_t;
                if (far_t < leave)
                    leave = far_t;
                if (enter > leave)
                    alive = 1'b0;
            end
        end
        r.hit     = alive;
        r.t_enter = alive ? enter[WORD_W-2:0] : '0;
        r.t_exit  = alive ? leave[WORD_W-2:0] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Box generation
    // ------------------------------------------------------------------

    // Half-extent of a box: tiny, up to one unit, up to 16 units or up to 1024 units, equally often.
    function automatic longint pick_span();
        case ($urandom_range(0, 3))
            0:       return longint'($urandom_range(0, 16));
            1:       return longint'($urandom_range(0, 32'h0001_0000));
            2:       return longint'($urandom_range(0, 32'h0010_0000));
            default: return longint'($urandom_range(0, 32'h0400_0000));
        endcase
    endfunction

    // Corner values that sit on the interesting boundaries of one axis.
    function automatic logic [WORD_W-1:0] corner_pick(int a);
        longint org;
        org = longint'($signed(ray_org[a]));
        case ($urandom_range(0, 7))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3:       return '1;
            4:       return WORD_W'(1);
            5:       return ray_org[a];
            6:       return WORD_W'(clamp_word(org + 1));
            default: return WORD_W'(clamp_word(org - 1));
        endcase
    endfunction

    // A box placed around a random point of the ray, so that most of them
    // get through all three axes; a few are knocked off the path or have
    // their corners swapped.
    function automatic box_t near_box();
        box_t   b;
        longint t;
        longint p;
        longint lo;
        longint hi;
        t = longint'($urandom_range(0, ray_limit));
        for (int a = 0; a < N_AXES; a++)
        begin
            p = longint'($signed(ray_org[a]))
                + ((longint'($signed(ray_dir[a])) * t) >>> FRAC_BITS);
            p = clamp_word(p);
            if ($urandom_range(0, 9) == 0)
                p = p + pick_span() - pick_span();
            lo = clamp_word(p - pick_span());
            hi = clamp_word(p + pick_span());
            if ($urandom_range(0, 4) == 0)
            begin
                b.lo[a] = WORD_W'(hi);
                b.hi[a] = WORD_W'(lo);
            end
            else
            begin
                b.lo[a] = WORD_W'(lo);
                b.hi[a] = WORD_W'(hi);
            end
        end
        return b;
    endfunction

    function automatic box_t make_box();
        box_t b;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            b = near_box();
        else if (roll < 85)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                b.lo[a] = $urandom();
                b.hi[a] = $urandom();
            end
        end
        else
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                b.lo[a] = corner_pick(a);
                b.hi[a] = corner_pick(a);
            end
        end
        return b;
    endfunction

    task automatic push_box(longint lx, longint ly, longint lz,
                            longint hx, longint hy, longint hz);
        box_t b;
        b.lo[0] = WORD_W'(lx);
        b.lo[1] = WORD_W'(ly);
        b.lo[2] = WORD_W'(lz);
        b.hi[0] = WORD_W'(hx);
        b.hi[1] = WORD_W'(hy);
        b.hi[2] = WORD_W'(hz);
        box_backlog.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // Register writes; only called with the pipeline empty
    // ------------------------------------------------------------------

    task automatic put_reg(logic [2:0] idx, logic [WORD_W-1:0] val);
        @(posedge clk);
        wr_en   <= 1'b1;
        wr_idx  <= idx;
        wr_data <= val;
    endtask

    task automatic write_ray(longint ox, longint oy, longint oz,
                             longint dx, longint dy, longint dz, longint lim);
        put_reg(REG_ORIGIN_X, WORD_W'(ox));
        put_reg(REG_ORIGIN_Y, WORD_W'(oy));
        put_reg(REG_ORIGIN_Z, WORD_W'(oz));
        put_reg(REG_DIR_X, WORD_W'(dx));
        put_reg(REG_DIR_Y, WORD_W'(dy));
        put_reg(REG_DIR_Z, WORD_W'(dz));
        put_reg(REG_T_LIMIT, WORD_W'(lim));
        @(posedge clk);
        wr_en <= 1'b0;
        ray_org[0] = WORD_W'(ox);
        ray_org[1] = WORD_W'(oy);
        ray_org[2] = WORD_W'(oz);
        ray_dir[0] = WORD_W'(dx);
        ray_dir[1] = WORD_W'(dy);
        ray_dir[2] = WORD_W'(dz);
        ray_limit  = (WORD_W-1)'(lim);
        ray_settings++;
        // push new boxes away from the clock edge
        @(negedge clk);
    endtask

    function automatic longint extreme_dir();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return longint'(S32_MAX);
            4:       return longint'(S32_MIN);
            5:       return fx(1);
            default: return fx(-1);
        endcase
    endfunction

    function automatic longint extreme_org();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return longint'(S32_MAX);
            2:       return longint'(S32_MIN);
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    function automatic longint near_dir();
        longint mag;
        if ($urandom_range(0, 5) == 0)
            return 0;
        mag = longint'($urandom_range(32'h0000_0100, 32'h0004_0000));
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic longint near_org();
        return longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
    endfunction

    task automatic set_random_ray(ray_kind_t kind);
        longint lim;
        case (kind)
            RAY_NEAR:
            begin
                lim = longint'($urandom_range(32'h0001_0000, 32'h0200_0000));
                write_ray(near_org(), near_org(), near_org(),
                          near_dir(), near_dir(), near_dir(), lim);
            end
            RAY_WILD:
            begin
                lim = longint'($urandom_range(0, 32'h7fff_ffff));
                write_ray(longint'($signed($urandom())), longint'($signed($urandom())),
                          longint'($signed($urandom())), longint'($signed($urandom())),
                          longint'($signed($urandom())), longint'($signed($urandom())),
                          lim);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       lim = 0;
                    1:       lim = 1;
                    2:       lim = 64'h7fff_ffff;
                    default: lim = longint'($urandom_range(0, 32'h7fff_ffff));
                endcase
                write_ray(extreme_org(), extreme_org(), extreme_org(),
                          extreme_dir(), extreme_dir(), extreme_dir(), lim);
            end
        endcase
    endtask

    // Hold off the sender until every box has come back, then let the
    // pipeline settle before anything touches the ray registers.
    task automatic wait_idle();
        while (box_backlog.size() != 0 || start || owed_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: one box beat per start, with random gaps between beats
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            // the beat on the ports is taken at this edge: predict it now,
            // with the ray registers as they stand
            if (start && !busy)
            begin
                owed_results.push_back(predict_slab(cur_box));
                boxes_sent++;
            end
            // a refused beat stays on the ports unchanged
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (box_backlog.size() != 0)
                begin
                    cur_box  = box_backlog.pop_front();
                    box_lo_x <= cur_box.lo[0];
                    box_lo_y <= cur_box.lo[1];
                    box_lo_z <= cur_box.lo[2];
                    box_hi_x <= cur_box.hi[0];
                    box_hi_y <= cur_box.hi[1];
                    box_hi_z <= cur_box.hi[2];
                    start    <= 1'b1;
                    // now and then run a stretch of back-to-back beats
                    if (calm_left > 0)
                    begin
                        calm_left--;
                        gap_left = 0;
                    end
                    else if ($urandom_range(0, 49) == 0)
                    begin
                        calm_left = $urandom_range(20, 80);
                        gap_left  = 0;
                    end
                    else
                        gap_left = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done beat against the oldest prediction
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            if (mismatch_count < SHOWN_ERRORS)
                $display("  result %0d: %s expected %h, got %h",
                         results_seen, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        slab_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                if (mismatch_count < SHOWN_ERRORS)
                    $display("  result %0d: no box waiting for it (hit %b, enter %h, exit %h)",
                             results_seen, hit, t_enter, t_exit);
                mismatch_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("hit", WORD_W'(want.hit), WORD_W'(hit));
                check_field("t_enter", WORD_W'(want.t_enter), WORD_W'(t_enter));
                check_field("t_exit", WORD_W'(want.t_exit), WORD_W'(t_exit));
                if (want.hit)
                    hits_seen++;
            end
            results_seen++;
        end
    end

    // Watchdog: drop the run if no channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1 || wr_en)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles, %0d results still owed",
                         quiet_cycles, owed_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at reset: zero direction on every axis and a zero
        // limit, so only boxes holding the origin hit, at [0, 0].
        push_box(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1));
        push_box(0, 0, 0, 0, 0, 0);
        // swapped corners on a parallel axis are a miss
        push_box(fx(1), fx(1), fx(1), fx(-1), fx(-1), fx(-1));
        push_box(fx(1), fx(1), fx(1), fx(2), fx(2), fx(2));
        wait_idle();

        // Ordinary ray: origin (0.5, -0.25, 1), direction (1, -2, 0.5).
        write_ray(64'sh8000, -64'sh4000, fx(1), fx(1), fx(-2), 64'sh8000, fx(1000));
        push_box(fx(1), fx(-5), fx(2), fx(3), fx(-1), fx(4));
        push_box(fx(3), fx(-1), fx(4), fx(1), fx(-5), fx(2));
        // box behind the origin on x
        push_box(fx(-10), fx(-5), fx(-3), fx(-5), fx(5), fx(10));
        // whole number range, then the two extreme corners
        push_box(longint'(S32_MIN), longint'(S32_MIN), longint'(S32_MIN),
                 longint'(S32_MAX), longint'(S32_MAX), longint'(S32_MAX));
        push_box(longint'(S32_MAX), longint'(S32_MAX), longint'(S32_MAX),
                 longint'(S32_MAX), longint'(S32_MAX), longint'(S32_MAX));
        push_box(longint'(S32_MIN), longint'(S32_MIN), longint'(S32_MIN),
                 longint'(S32_MIN), longint'(S32_MIN), longint'(S32_MIN));
        // x and y agree, z empties the interval
        push_box(fx(1), fx(-5), fx(100), fx(3), fx(-1), fx(101));
        // exit clipped by the limit
        push_box(fx(999), fx(-9999), fx(-9999), fx(1001), fx(9999), fx(9999));
        wait_idle();

        // Saturating distances: one-LSB and extreme directions, full limit.
        write_ray(0, 0, 0, 1, longint'(S32_MIN), longint'(S32_MAX), 64'h7fff_ffff);
        push_box(longint'(S32_MIN), longint'(S32_MIN), longint'(S32_MIN),
                 longint'(S32_MAX), longint'(S32_MAX), longint'(S32_MAX));
        push_box(-1, -1, -1, 1, 1, 1);
        push_box(fx(-3), fx(-3), fx(-3), fx(5), fx(5), fx(5));
        push_box(fx(2), 0, 0, fx(2), 0, 0);
        wait_idle();

        // Zero limit with y parallel and the origin on the top of the range.
        write_ray(0, longint'(S32_MAX), 0, fx(1), 0, -1, 0);
        push_box(fx(-1), longint'(S32_MAX), fx(-1), fx(1), longint'(S32_MAX), fx(1));
        push_box(fx(-1), longint'(S32_MIN), fx(-1), fx(1), longint'(S32_MAX) - 1, fx(1));
        // exit one LSB short of zero is widened back onto it
        push_box(fx(-2), longint'(S32_MAX), fx(-1), -1, longint'(S32_MAX), fx(1));
        wait_idle();

        // Random rays, half of them short ones that boxes can actually hit.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p % 4 == 1)
                set_random_ray(RAY_WILD);
            else if (p % 4 == 3)
                set_random_ray(RAY_EXTREME);
            else
                set_random_ray(RAY_NEAR);
            for (int i = 0; i < BOXES_PER_PHASE; i++)
                box_backlog.push_back(make_box());
            wait_idle();
        end

        $display("Sent %0d boxes under %0d ray settings; %0d results checked, %0d of them hits.",
                 boxes_sent, ray_settings, results_seen, hits_seen);
        $display("Mismatches: %0d, results still owed: %0d.",
                 mismatch_count, owed_results.size());
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
